// File: src/lbct_pkg.sv
package lbct_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CS            = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // pipeline stage indexes
  localparam int ST_IN = 0;
  localparam int ST_RQ = 1;
  localparam int ST_RM = 2;
  localparam int ST_WR = 3;
  localparam int ST_QD = 4;
  localparam int ST_CO = 5;
  localparam int ST_QA = ST_CO + CS;
  localparam int ST_P1 = ST_QA + 1;
  localparam int ST_P2 = ST_QA + 2;
  localparam int ST_M1 = ST_QA + 3;
  localparam int ST_M2 = ST_QA + 4;
  localparam int NST   = ST_M2 + 1;

  localparam logic [1:0] CT_RECT = 2'd0;
  localparam logic [1:0] CT_CYL  = 2'd1;
  localparam logic [1:0] CT_SPH  = 2'd2;

  localparam logic [2:0] REG_COORD_TYPE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd3;
  localparam logic [2:0] REG_ROW_X      = 3'd4;
  localparam logic [2:0] REG_ROW_Y      = 3'd5;
  localparam logic [2:0] REG_ROW_Z      = 3'd6;

  // one full turn in Q16.16 degrees, and its reciprocal scaled by 2^56, rounded up
  localparam logic signed [33:0] TURN_Q16 = 34'sd23592960;
  localparam logic        [32:0] TURN_RCP = 33'd3054198967;
  localparam logic        [24:0] DEG90_Q16 = 25'd5898240;
  localparam logic signed [31:0] START_X  = 32'sd652032874;

  typedef struct packed {
    logic signed [31:0] first_coord;
    logic signed [31:0] second_coord;
    logic signed [31:0] third_coord;
  } in_t;

  typedef struct packed {
    logic signed [31:0] basic_x;
    logic signed [31:0] basic_y;
    logic signed [31:0] basic_z;
  } out_t;

  function automatic logic signed [31:0] atan_deg(input int i);
    logic signed [31:0] v;
    case (i)
      0:       v = 32'sd754974720;
      1:       v = 32'sd445687602;
      2:       v = 32'sd235489088;
      3:       v = 32'sd119537938;
      4:       v = 32'sd60000934;
      5:       v = 32'sd30029717;
      6:       v = 32'sd15018523;
      7:       v = 32'sd7509720;
      8:       v = 32'sd3754917;
      9:       v = 32'sd1877466;
      10:      v = 32'sd938734;
      11:      v = 32'sd469367;
      12:      v = 32'sd234684;
      13:      v = 32'sd117342;
      14:      v = 32'sd58671;
      15:      v = 32'sd29335;
      16:      v = 32'sd14668;
      17:      v = 32'sd7334;
      18:      v = 32'sd3667;
      19:      v = 32'sd1833;
      20:      v = 32'sd917;
      21:      v = 32'sd458;
      22:      v = 32'sd229;
      23:      v = 32'sd115;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // round half up by 30 bits
  function automatic logic signed [33:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd536870912;
    t = t >>> 30;
    return t[33:0];
  endfunction

endpackage

// File: src/local_to_basic_coordinate_transform_unit.sv
// Throughput: one point per cycle while out_stall is low.
// One unrolled CORDIC stage per pipeline register.
// Each stage holds on its own when the next is full, so bubbles close up under stall.
// Reset (rst, synchronous): pipeline empties, type rectangular, zero origin,
// identity axis matrix.
module local_to_basic_coordinate_transform_unit
  import lbct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic        [1:0]  coord_type;
  logic signed [31:0] origin [3];
  logic        [47:0] mrow   [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_type <= CT_RECT;
      origin[0]  <= '0;
      origin[1]  <= '0;
      origin[2]  <= '0;
      mrow[0]    <= 48'd16384;
      mrow[1]    <= 48'd16384 << 16;
      mrow[2]    <= 48'd16384 << 32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COORD_TYPE: coord_type <= cfg_data[1:0];
        REG_ORIGIN_X:   origin[0]  <= cfg_data[31:0];
        REG_ORIGIN_Y:   origin[1]  <= cfg_data[31:0];
        REG_ORIGIN_Z:   origin[2]  <= cfg_data[31:0];
        REG_ROW_X:      mrow[0]    <= cfg_data;
        REG_ROW_Y:      mrow[1]    <= cfg_data;
        REG_ROW_Z:      mrow[2]    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [NST-1:0] vld;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // coordinates travel alongside up to the product stage
  in_t crd [ST_P1+1];

  always_ff @(posedge clk) begin
    if (adv[ST_IN]) crd[0] <= in_data;
    for (int k = 1; k <= ST_P1; k++) begin
      if (adv[k]) crd[k] <= crd[k-1];
    end
  end

  // angle reduction modulo 360 degrees; index 0 theta, 1 phi
  logic signed [8:0]  rq_q   [2];
  logic signed [33:0] rm_r   [2];
  logic        [24:0] wr_m   [2];
  logic        [1:0]  qd_q   [2];
  logic signed [31:0] qd_z   [2];

  logic signed [31:0] ang_in [2];
  logic signed [31:0] ang_rm [2];
  assign ang_in[0] = crd[ST_IN].second_coord;
  assign ang_in[1] = crd[ST_IN].third_coord;
  assign ang_rm[0] = crd[ST_RQ].second_coord;
  assign ang_rm[1] = crd[ST_RQ].third_coord;

  for (genvar j = 0; j < 2; j++) begin : g_red
    logic signed [64:0] prod;
    logic signed [33:0] r_next;
    logic signed [33:0] w_next;
    logic        [1:0]  q_next;
    logic        [24:0] res_next;

    assign prod   = 65'(ang_in[j]) * $signed({32'd0, TURN_RCP});
    assign r_next = 34'(ang_rm[j]) - 34'(34'(rq_q[j]) * TURN_Q16);

    always_comb begin
      priority if (rm_r[j] < 0) begin
        w_next = rm_r[j] + TURN_Q16;
      end else if (rm_r[j] >= TURN_Q16) begin
        w_next = rm_r[j] - TURN_Q16;
      end else begin
        w_next = rm_r[j];
      end
      priority if (wr_m[j] >= 25'(3 * DEG90_Q16)) begin
        q_next = 2'd3;
      end else if (wr_m[j] >= 25'(2 * DEG90_Q16)) begin
        q_next = 2'd2;
      end else if (wr_m[j] >= DEG90_Q16) begin
        q_next = 2'd1;
      end else begin
        q_next = 2'd0;
      end
      res_next = wr_m[j] - 25'(27'(q_next) * 27'(DEG90_Q16));
    end

    always_ff @(posedge clk) begin
      if (adv[ST_RQ]) rq_q[j] <= prod[64:56];
      if (adv[ST_RM]) rm_r[j] <= r_next;
      if (adv[ST_WR]) wr_m[j] <= w_next[24:0];
      if (adv[ST_QD]) begin
        qd_q[j] <= q_next;
        // residual stays below 90 degrees, so 24 bits carry it
        qd_z[j] <= {res_next[23:0], 8'd0};
      end
    end
  end

  // unrolled CORDIC, one iteration per stage
  logic signed [31:0] cx [2][CS];
  logic signed [31:0] cy [2][CS];
  logic signed [31:0] cz [2][CS];
  logic        [1:0]  cq [2][CS];

  for (genvar j = 0; j < 2; j++) begin : g_ang
    for (genvar i = 0; i < CS; i++) begin : g_cor
      logic signed [31:0] xi, yi, zi;
      logic        [1:0]  qi;
      if (i == 0) begin : g_first
        assign xi = START_X;
        assign yi = '0;
        assign zi = qd_z[j];
        assign qi = qd_q[j];
      end else begin : g_rest
        assign xi = cx[j][i-1];
        assign yi = cy[j][i-1];
        assign zi = cz[j][i-1];
        assign qi = cq[j][i-1];
      end
      always_ff @(posedge clk) begin
        if (adv[ST_CO+i]) begin
          cq[j][i] <= qi;
          if (zi >= 0) begin
            cx[j][i] <= xi - (yi >>> i);
            cy[j][i] <= yi + (xi >>> i);
            cz[j][i] <= zi - atan_deg(i);
          end else begin
            cx[j][i] <= xi + (yi >>> i);
            cy[j][i] <= yi - (xi >>> i);
            cz[j][i] <= zi + atan_deg(i);
          end
        end
      end
    end
  end

  // quadrant fix-up: cosine and sine per angle
  logic signed [31:0] cs_c [2];
  logic signed [31:0] cs_s [2];

  for (genvar j = 0; j < 2; j++) begin : g_qa
    logic signed [31:0] x, y;
    assign x = cx[j][CS-1];
    assign y = cy[j][CS-1];
    always_ff @(posedge clk) begin
      if (adv[ST_QA]) begin
        unique case (cq[j][CS-1])
          2'd1:    begin cs_c[j] <= -y; cs_s[j] <= x;  end
          2'd2:    begin cs_c[j] <= -x; cs_s[j] <= -y; end
          2'd3:    begin cs_c[j] <= y;  cs_s[j] <= -x; end
          default: begin cs_c[j] <= x;  cs_s[j] <= y;  end
        endcase
      end
    end
  end

  // length products
  logic signed [33:0] p1_ac, p1_as, p1_t, p1_zc;
  logic signed [31:0] p1_ct, p1_st;
  logic signed [31:0] p1_b, p1_c3;
  logic signed [31:0] a_qa;
  assign a_qa = crd[ST_QA].first_coord;

  always_ff @(posedge clk) begin
    if (adv[ST_P1]) begin
      p1_ac <= rnd30(66'(a_qa) * 66'(cs_c[0]));
      p1_as <= rnd30(66'(a_qa) * 66'(cs_s[0]));
      p1_t  <= rnd30(66'(a_qa) * 66'(cs_s[1]));
      p1_zc <= rnd30(66'(a_qa) * 66'(cs_c[1]));
      p1_ct <= cs_c[0];
      p1_st <= cs_s[0];
      p1_b  <= crd[ST_QA].second_coord;
      p1_c3 <= crd[ST_QA].third_coord;
    end
  end

  logic signed [33:0] pl [3];
  logic signed [31:0] a_p1;
  assign a_p1 = crd[ST_P1].first_coord;

  always_ff @(posedge clk) begin
    if (adv[ST_P2]) begin
      priority if (coord_type == CT_CYL) begin
        pl[0] <= p1_ac;
        pl[1] <= p1_as;
        pl[2] <= 34'(p1_c3);
      end else if (coord_type == CT_SPH) begin
        pl[0] <= rnd30(66'(p1_t) * 66'(p1_ct));
        pl[1] <= rnd30(66'(p1_t) * 66'(p1_st));
        pl[2] <= p1_zc;
      end else begin
        pl[0] <= 34'(a_p1);
        pl[1] <= 34'(p1_b);
        pl[2] <= 34'(p1_c3);
      end
    end
  end

  // axis matrix and origin
  logic signed [49:0] mp [3][3];

  always_ff @(posedge clk) begin
    if (adv[ST_M1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          mp[r][k] <= 50'($signed(mrow[r][16*k +: 16])) * 50'(pl[k]);
        end
      end
    end
  end

  logic signed [31:0] row_sat [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [51:0] sum;
    logic signed [51:0] rs;
    logic signed [31:0] sat;
    always_comb begin
      sum = (52'(origin[r]) <<< 14) + 52'(mp[r][0]) + 52'(mp[r][1]) + 52'(mp[r][2]);
      rs  = (sum + 52'sd8192) >>> 14;
      priority if (rs > 52'sd2147483647) begin
        sat = 32'sh7fffffff;
      end else if (rs < -52'sd2147483648) begin
        sat = 32'sh80000000;
      end else begin
        sat = rs[31:0];
      end
    end
    assign row_sat[r] = sat;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_M2]) begin
      out_data <= '{basic_x: row_sat[0], basic_y: row_sat[1], basic_z: row_sat[2]};
    end
  end

endmodule

// File: bench/lbct_checker.sv
`default_nettype none

module lbct_checker
  import lbct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_t         in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_t        out_data,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QUARTER = 64'sd1509949440;
  localparam longint TURN    = 64'sd6039797760;
  localparam longint XSTART  = 64'sd652032874;
  localparam longint ARCTAN [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};

  logic [1:0]         frame_kind;
  logic signed [31:0] org_x, org_y, org_z;
  logic [47:0]        axis_x, axis_y, axis_z;
  out_t               basic_q[$];
  int                 err_cnt, ok_cnt;

  function automatic longint round_by(longint v, int sh);
    longint t;
    t = v + (64'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

  // cosine and sine of a Q16.16 angle in degrees, both Q2.30
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint m, z, x, y, dx, dy, q;
    m = (ang * 256) % TURN;
    if (m < 0) m += TURN;
    q = m / QUARTER;
    z = m - q * QUARTER;
    x = XSTART;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    case (q)
      1:       begin c = -y; s = x;  end
      2:       begin c = -x; s = -y; end
      3:       begin c = y;  s = -x; end
      default: begin c = x;  s = y;  end
    endcase
  endfunction

  function automatic logic signed [31:0] axis_sum(logic [47:0] row, logic signed [31:0] org,
                                                  longint p0, longint p1, longint p2);
    longint acc;
    acc = longint'(org) * 16384;
    acc += longint'($signed(row[15:0])) * p0;
    acc += longint'($signed(row[31:16])) * p1;
    acc += longint'($signed(row[47:32])) * p2;
    acc = round_by(acc, 14);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic out_t predict_point(in_t pt);
    longint a, b, c3, ct, st, cp, sp, t, p0, p1, p2;
    out_t r;
    a  = pt.first_coord;
    b  = pt.second_coord;
    c3 = pt.third_coord;
    if (frame_kind == CT_CYL) begin
      sin_cos(b, ct, st);
      p0 = round_by(a * ct, 30);
      p1 = round_by(a * st, 30);
      p2 = c3;
    end else if (frame_kind == CT_SPH) begin
      sin_cos(b, ct, st);
      sin_cos(c3, cp, sp);
      t  = round_by(a * sp, 30);
      p0 = round_by(t * ct, 30);
      p1 = round_by(t * st, 30);
      p2 = round_by(a * cp, 30);
    end else begin
      p0 = a; p1 = b; p2 = c3;
    end
    r.basic_x = axis_sum(axis_x, org_x, p0, p1, p2);
    r.basic_y = axis_sum(axis_y, org_y, p0, p1, p2);
    r.basic_z = axis_sum(axis_z, org_z, p0, p1, p2);
    return r;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      frame_kind = CT_RECT;
      org_x = '0; org_y = '0; org_z = '0;
      axis_x = 48'd16384;
      axis_y = 48'd16384 << 16;
      axis_z = 48'd16384 << 32;
      basic_q.delete();
      err_cnt = 0;
      ok_cnt = 0;
    end else begin
      if (in_valid && !in_stall) basic_q.push_back(predict_point(in_data));
      if (out_valid && !out_stall) begin
        if (basic_q.size() == 0) begin
          err_cnt++;
          $error("result transfer with nothing expected: %h", out_data);
        end else begin
          e = basic_q.pop_front();
          ok_cnt++;
          if (out_data.basic_x !== e.basic_x) begin
            err_cnt++;
            $error("basic_x: expected %0d, got %0d", e.basic_x, out_data.basic_x);
          end
          if (out_data.basic_y !== e.basic_y) begin
            err_cnt++;
            $error("basic_y: expected %0d, got %0d", e.basic_y, out_data.basic_y);
          end
          if (out_data.basic_z !== e.basic_z) begin
            err_cnt++;
            $error("basic_z: expected %0d, got %0d", e.basic_z, out_data.basic_z);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COORD_TYPE: frame_kind = cfg_data[1:0];
          REG_ORIGIN_X:   org_x = cfg_data[31:0];
          REG_ORIGIN_Y:   org_y = cfg_data[31:0];
          REG_ORIGIN_Z:   org_z = cfg_data[31:0];
          REG_ROW_X:      axis_x = cfg_data;
          REG_ROW_Y:      axis_y = cfg_data;
          REG_ROW_Z:      axis_z = cfg_data;
          default: ;
        endcase
      end
    end
    errors  <= err_cnt;
    pending <= basic_q.size();
    checked <= ok_cnt;
  end

endmodule

// File: bench/local_to_basic_coordinate_transform_unit_tb.sv
`default_nettype none

module local_to_basic_coordinate_transform_unit_tb;
  import lbct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] CT_SPARE   = 2'd3;
  localparam int         STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  int errors, pending, checked;
  int hold_cycles = 0;
  bit calm = 1'b0;
  int idle_watch = 0;
  int points_sent = 0;
  int cfg_writes = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  local_to_basic_coordinate_transform_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lbct_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending, .checked
  );

  // receiver back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_watch <= 0;
    else
      idle_watch <= idle_watch + 1;
    if (idle_watch >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_point(in_t p);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [47:0] rand_axes(bit extreme);
    logic [47:0] v;
    for (int k = 0; k < 3; k++)
      v[16*k +: 16] = extreme ? ($urandom_range(1) ? 16'h7FFF : 16'h8000)
                              : 16'($urandom_range(32768) - 16384);
    return v;
  endfunction

  function automatic logic signed [31:0] rand_field(bit full);
    if (full || $urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(2 * 8388608)) - 32'sd8388608;
  endfunction

  function automatic in_t rand_point();
    in_t p;
    bit full;
    full = ($urandom_range(3) == 0);
    p.first_coord  = rand_field(full);
    p.second_coord = rand_field(full);
    p.third_coord  = rand_field(full);
    return p;
  endfunction

  function automatic in_t mk(int a, int b, int c);
    in_t p;
    p.first_coord = a; p.second_coord = b; p.third_coord = c;
    return p;
  endfunction

  localparam int DEG = 65536;

  initial begin
    logic [1:0] kinds [4] = '{CT_RECT, CT_CYL, CT_SPH, CT_SPARE};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: identity matrix, each frame kind, angle and length extremes
    foreach (kinds[k]) begin
      write_reg(REG_COORD_TYPE, 48'(kinds[k]));
      send_point(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
      send_point(mk(10 * DEG, 0, 0));
      send_point(mk(10 * DEG, 90 * DEG, 90 * DEG));
      send_point(mk(-10 * DEG, 180 * DEG, 270 * DEG));
      send_point(mk(7 * DEG, -90 * DEG, 360 * DEG));
      send_point(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
      drain();
    end

    // random phases, each with its own settings
    for (int ph = 0; ph < 8; ph++) begin
      bit extreme;
      extreme = (ph == 1 || ph == 5);
      write_reg(REG_COORD_TYPE, 48'(kinds[ph % 4]));
      write_reg(REG_ORIGIN_X, extreme ? 48'h7FFFFFFF : 48'($urandom));
      write_reg(REG_ORIGIN_Y, extreme ? 48'h80000000 : 48'($urandom));
      write_reg(REG_ORIGIN_Z, extreme ? 48'h0 : 48'(rand_field(1'b0)));
      write_reg(REG_ROW_X, rand_axes(extreme));
      write_reg(REG_ROW_Y, rand_axes(extreme));
      write_reg(REG_ROW_Z, rand_axes(extreme));
      write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
      calm = (ph == 3);
      for (int n = 0; n < 135; n++) begin
        // fill the pipeline against a long receiver hold
        if (ph == 2 && n == 20) hold_cycles = 300;
        // pause until everything has arrived
        if (ph == 6 && n == 60) drain();
        send_point(rand_point());
      end
      calm = 1'b0;
      drain();
    end

    $display("%0d points sent over 4 frame kinds and 8 register settings,", points_sent);
    $display("%0d results checked, %0d register writes", checked, cfg_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
